// ----- rtl/core/vertex_rotate_project_macros.svh -----
// Assertion macros used by the checker file.
`ifndef VERTEX_ROTATE_PROJECT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define VRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define VRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/vrp_pkg.sv -----
`default_nettype none
package vrp_pkg;

   localparam int VERTEX_COUNT = 8;
   localparam int EMIT_COUNT   = 8;
   localparam int IDX_W        = $clog2(VERTEX_COUNT);
   localparam int COORD_W      = 16;
   localparam int PIX_W        = 12;
   localparam int SCR_W        = 20;
   localparam int PROD_W       = 33;
   localparam int ACC_W        = 34;
   localparam int QUOT_W       = 21;
   localparam int DVND_W       = 34;
   localparam int DVSR_W       = 17;
   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 48;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COS_X    = 3'd0,
      REG_SIN_X    = 3'd1,
      REG_COS_Y    = 3'd2,
      REG_SIN_Y    = 3'd3,
      REG_SCALE    = 3'd4,
      REG_CENTER_X = 3'd5,
      REG_CENTER_Y = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   // Cube corner at +-1.0 (Q4.12) for a slot that was never loaded
   function automatic vertex_type reset_vertex(input logic [IDX_W-1:0] idx);
      logic [2:0] c;
      vertex_type v;
      c   = 3'(idx);
      v.x = (c == 3'd1 || c == 3'd2 || c == 3'd5 || c == 3'd6) ? 16'sd4096 : -16'sd4096;
      v.y = (c == 3'd2 || c == 3'd3 || c == 3'd6 || c == 3'd7) ? 16'sd4096 : -16'sd4096;
      v.z = c[2] ? 16'sd4096 : -16'sd4096;
      return v;
   endfunction

   // Round Q.26 to Q.12 (ties up), saturate to 16 bits
   function automatic logic signed [COORD_W-1:0] round_sat14(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0]  t;
      logic signed [ACC_W-14:0] q;
      t = {v[ACC_W-1], v} + 35'sd8192;
      q = t[ACC_W:14];
      if (q > 21'sd32767) begin
         return 16'sh7fff;
      end else if (q < -21'sd32768) begin
         return 16'sh8000;
      end
      return q[COORD_W-1:0];
   endfunction

   // Signed quotient plus center in Q16.4, saturated to 20 bits
   function automatic logic signed [SCR_W-1:0] project_sat(input logic neg,
                                                           input logic [QUOT_W-1:0] q,
                                                           input logic [PIX_W-1:0] center);
      logic signed [QUOT_W+1:0] r;
      r = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      r = r + $signed({7'd0, center, 4'd0});
      if (r > 23'sd524287) begin
         return 20'sh7ffff;
      end else if (r < -23'sd524288) begin
         return 20'sh80000;
      end
      return r[SCR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/vrp_divider.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle. The dividend must be
// below divisor * 2**QUOT_W so the quotient fits.
module vrp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vrp_pkg::DVND_W-1:0]  dividend,
   input  logic [vrp_pkg::DVSR_W-1:0]  divisor,
   output logic                        done,
   output logic [vrp_pkg::QUOT_W-1:0]  quotient
);
   import vrp_pkg::*;

   logic [DVSR_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0]  dvsr_ff;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DVSR_W:0]    trial;

   // One shift-subtract step
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUOT_W-1]};
      if (start) begin
         rem_in  = DVSR_W'(dividend[DVND_W-1:QUOT_W]);
         quo_in  = dividend[QUOT_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = DVSR_W'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVSR_W-1:0];
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/core/vertex_rotate_project.sv -----
// Load beat: taken in idle; no response beat.
// Frame beat: for each vertex in turn, a store read, 12 multiply/accumulate steps on one
// shared 16x17 multiplier, the two bit-serial dividers and a handoff to the response
// register, which waits while a beat is held unaccepted; no request is taken until the frame ends.
// Synchronous active-high reset restores the configuration defaults and marks all
// store slots unwritten, so they read as the cube corners; no clearing pass.
`default_nettype none
module vertex_rotate_project (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] vertex_index, [18:3] pos_x, [34:19] pos_y, [50:35] pos_z, rest zero
   input  logic [vrp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] opcode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] out_index, [22:3] screen_x, [42:23] screen_y, rest zero
   output logic [vrp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] clipped
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [vrp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [vrp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import vrp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   localparam logic [3:0] STEP_END = 4'd11;

   // Configuration registers
   logic signed [15:0] cos_x_ff, sin_x_ff, cos_y_ff, sin_y_ff;
   logic [PIX_W-1:0]   scale_ff, center_x_ff, center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff    <= 16'sd16383;
         sin_x_ff    <= 16'sd164;
         cos_y_ff    <= 16'sd16381;
         sin_y_ff    <= 16'sd328;
         scale_ff    <= 12'd200;
         center_x_ff <= 12'd480;
         center_y_ff <= 12'd270;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_COS_X:    cos_x_ff    <= csr_wdata;
            REG_SIN_X:    sin_x_ff    <= csr_wdata;
            REG_COS_Y:    cos_y_ff    <= csr_wdata;
            REG_SIN_Y:    sin_y_ff    <= csr_wdata;
            REG_SCALE:    scale_ff    <= csr_wdata[PIX_W-1:0];
            REG_CENTER_X: center_x_ff <= csr_wdata[PIX_W-1:0];
            REG_CENTER_Y: center_y_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Request fields
   logic [IDX_W-1:0]   req_index;
   vertex_type         req_vertex;
   logic               req_beat;

   assign req_index    = req_tdata[IDX_W-1:0];
   assign req_vertex.x = req_tdata[18:3];
   assign req_vertex.y = req_tdata[34:19];
   assign req_vertex.z = req_tdata[50:35];
   assign req_beat     = req_tvalid && req_tready;

   // Sequencer registers
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        vidx_ff, vidx_in;
   logic [3:0]              step_ff, step_in;

   // Vertex store
   vertex_type              mem [VERTEX_COUNT];
   vertex_type              rd_data_ff;
   logic                    rd_valid_ff;
   logic [VERTEX_COUNT-1:0] valid_ff;
   logic                    mem_we, mem_re;
   logic [IDX_W-1:0]        mem_waddr;
   vertex_type              mem_wdata;
   vertex_type              vtx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[vidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= valid_ff[vidx_ff];
         end
      end
   end

   // Unwritten slots read as their cube corner
   assign vtx = rd_valid_ff ? rd_data_ff : reset_vertex(vidx_ff);

   // Shared multiplier and accumulator
   logic signed [COORD_W-1:0] mul_a;
   logic signed [COORD_W:0]   mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [COORD_W-1:0] z1_ff, y1_ff, x2_ff, z2_ff;
   logic signed [PROD_W-1:0]  num_x_ff, num_y_ff;
   logic signed [ACC_W-1:0]   prod_ext;

   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = vtx.y; mul_b = {sin_x_ff[15], sin_x_ff}; end
         4'd1:    begin mul_a = vtx.z; mul_b = {cos_x_ff[15], cos_x_ff}; end
         4'd2:    begin mul_a = vtx.y; mul_b = {cos_x_ff[15], cos_x_ff}; end
         4'd3:    begin mul_a = vtx.z; mul_b = {sin_x_ff[15], sin_x_ff}; end
         4'd4:    begin mul_a = vtx.x; mul_b = {cos_y_ff[15], cos_y_ff}; end
         4'd5:    begin mul_a = z1_ff; mul_b = {sin_y_ff[15], sin_y_ff}; end
         4'd6:    begin mul_a = z1_ff; mul_b = {cos_y_ff[15], cos_y_ff}; end
         4'd7:    begin mul_a = vtx.x; mul_b = {sin_y_ff[15], sin_y_ff}; end
         4'd8:    begin mul_a = x2_ff; mul_b = $signed({5'd0, scale_ff}); end
         4'd9:    begin mul_a = y1_ff; mul_b = $signed({5'd0, scale_ff}); end
         default: begin mul_a = '0;    mul_b = '0; end
      endcase
   end

   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};

   // Operands feed prod_ff, prod_ff feeds acc_ff, and acc_ff is rounded into z1, y1, x2, z2
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_MUL) begin
         case (step_ff)
            4'd1, 4'd3, 4'd5, 4'd7: acc_ff <= prod_ext;
            4'd2, 4'd6:             acc_ff <= acc_ff + prod_ext;
            4'd4, 4'd8:             acc_ff <= acc_ff - prod_ext;
            default: ;
         endcase
         case (step_ff)
            4'd3:    z1_ff <= round_sat14(acc_ff);
            4'd5:    y1_ff <= round_sat14(acc_ff);
            4'd7:    x2_ff <= round_sat14(acc_ff);
            4'd9:    begin
               z2_ff    <= round_sat14(acc_ff);
               num_x_ff <= prod_ff;
            end
            4'd10:   num_y_ff <= prod_ff;
            default: ;
         endcase
      end
   end

   // Depth and divider operands
   logic signed [17:0]  depth;
   logic                clip_now;
   logic [DVSR_W-1:0]   divisor;
   logic [PROD_W-1:0]   mag_x, mag_y;
   logic [DVND_W-1:0]   dvnd_x, dvnd_y;
   logic                div_start;
   logic                div_done_x, div_done_y;
   logic [QUOT_W-1:0]   quo_x, quo_y;
   logic                neg_x_ff, neg_y_ff, clip_ff;

   assign depth    = 18'sd40960 + {{2{z2_ff[15]}}, z2_ff};
   assign clip_now = depth[17] || (depth == 18'sd0);
   assign divisor  = depth[DVSR_W-1:0];
   assign mag_x    = num_x_ff[PROD_W-1] ? PROD_W'(-num_x_ff) : PROD_W'(num_x_ff);
   assign mag_y    = num_y_ff[PROD_W-1] ? PROD_W'(-num_y_ff) : PROD_W'(num_y_ff);
   // |v*scale| < 2**27; add half the divisor for rounding
   assign dvnd_x   = DVND_W'({mag_x[27:0], 6'd0}) + DVND_W'(divisor[DVSR_W-1:1]);
   assign dvnd_y   = DVND_W'({mag_y[27:0], 6'd0}) + DVND_W'(divisor[DVSR_W-1:1]);
   assign div_start = (state_ff == ST_MUL) && (step_ff == STEP_END);

   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_x_ff <= num_x_ff[PROD_W-1];
         neg_y_ff <= num_y_ff[PROD_W-1];
         clip_ff  <= clip_now;
      end
   end

   vrp_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvnd_x),
      .divisor  (divisor),
      .done     (div_done_x),
      .quotient (quo_x)
   );

   vrp_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvnd_y),
      .divisor  (divisor),
      .done     (div_done_y),
      .quotient (quo_y)
   );

   // Response register
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic signed [SCR_W-1:0]  rsp_sx_ff, rsp_sy_ff;
   logic                     rsp_clip_ff, rsp_last_ff;
   logic                     out_free, emit_slot, emit_go, rsp_load;
   logic signed [SCR_W-1:0]  scr_x, scr_y;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_slot = int'(vidx_ff) < EMIT_COUNT;
   assign emit_go   = (state_ff == ST_EMIT) && (!emit_slot || out_free);
   assign rsp_load  = emit_go && emit_slot;
   assign scr_x = clip_ff ? $signed({4'd0, center_x_ff, 4'd0})
                          : project_sat(neg_x_ff, quo_x, center_x_ff);
   assign scr_y = clip_ff ? $signed({4'd0, center_y_ff, 4'd0})
                          : project_sat(neg_y_ff, quo_y, center_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= vidx_ff;
         rsp_sx_ff    <= scr_x;
         rsp_sy_ff    <= scr_y;
         rsp_clip_ff  <= clip_ff;
         rsp_last_ff  <= int'(vidx_ff) == EMIT_COUNT - 1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_sy_ff, rsp_sx_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_clip_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign req_tready = (state_ff == ST_IDLE);

   // Store write port: loads in idle, write-back of the rotated vertex
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = vidx_ff;
      mem_wdata = '{z: z2_ff, y: y1_ff, x: x2_ff};
      if (req_beat && req_tuser == OP_LOAD && int'(req_index) < VERTEX_COUNT) begin
         mem_we    = 1'b1;
         mem_waddr = req_index;
         mem_wdata = req_vertex;
      end else if (div_start) begin
         mem_we = 1'b1;
      end
   end

   assign mem_re = (state_ff == ST_READ);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      vidx_in  = vidx_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_tuser == OP_FRAME) begin
               vidx_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_END) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done_x && div_done_y) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (int'(vidx_ff) == VERTEX_COUNT - 1) begin
                  state_in = ST_IDLE;
               end else begin
                  vidx_in  = vidx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vidx_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vidx_ff  <= vidx_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/vrp_checker.sv -----
`default_nettype none
`include "vertex_rotate_project_macros.svh"
// Port-level checks on the vertex projector
module vrp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [vrp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast
);
   import vrp_pkg::*;

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(EMIT_COUNT - 1);

   logic             frame_beat, last_beat;
   logic [IDX_W-1:0] rsp_index;

   assign frame_beat = req_tvalid && req_tready && (req_tuser == OP_FRAME);
   assign last_beat  = rsp_tvalid && rsp_tlast;
   assign rsp_index  = rsp_tdata[IDX_W-1:0];

   // Response beat is held until taken
   `VRP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")

   // Nothing is offered right after reset
   `VRP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   // A frame beat closes the request side as the vertex walk begins
   `VRP_ASSERT(a_frame_busy, clock, reset, frame_beat |=> !req_tready, "ready during frame")

   // Last beat of a frame carries the final emitted index
   `VRP_ASSERT(a_last_index, clock, reset, last_beat |-> rsp_index == LAST_INDEX, "bad tlast")

endmodule

bind vertex_rotate_project vrp_checker u_vrp_checker (.*);
`default_nettype wire
